// File: hdl/position_to_velocity_controller_top_macros.svh
// ----------------------------------------------------------------------------
// position_to_velocity_controller_top_macros
// Assertion macros for the position to velocity controller.
// ----------------------------------------------------------------------------
`ifndef POSITION_TO_VELOCITY_CONTROLLER_TOP_MACROS_SVH
`define POSITION_TO_VELOCITY_CONTROLLER_TOP_MACROS_SVH
// Check that an implication holds at every clock edge outside reset.
`define PVC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pvc check failed");
// Check that an implication holds in the cycle after its antecedent.
`define PVC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pvc check failed");
`endif

// File: hdl/pvc_pkg.sv
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared constants, command codes and datapath control types.
// ----------------------------------------------------------------------------
package pvc_pkg;

   localparam int CordicSteps = 16;
   localparam int StepW = $clog2(CordicSteps + 1);

   localparam logic [1:0] CMD_REF  = 2'd0;
   localparam logic [1:0] CMD_POS  = 2'd1;
   localparam logic [1:0] CMD_ATT  = 2'd2;
   localparam logic [1:0] CMD_TICK = 2'd3;

   localparam logic [2:0] REG_GAIN_XY   = 3'd0;
   localparam logic [2:0] REG_GAIN_Z    = 3'd1;
   localparam logic [2:0] REG_GAIN_YAW  = 3'd2;
   localparam logic [2:0] REG_SPEED_LIM = 3'd3;
   localparam logic [2:0] REG_TURN_LIM  = 3'd4;
   localparam logic [2:0] REG_SMOOTHING = 3'd5;

   localparam logic signed [15:0] PiQ13     = 16'sd25736;
   localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;

   // datapath operations
   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_LOAD    = 4'd1;  // capture item, store coordinates
   localparam logic [3:0] OP_QPREP   = 4'd2;  // quaternion products
   localparam logic [3:0] OP_QROT    = 4'd3;  // quadrant pre-rotation
   localparam logic [3:0] OP_CSTEP   = 4'd4;  // one CORDIC step
   localparam logic [3:0] OP_QDONE   = 4'd5;  // store heading
   localparam logic [3:0] OP_SMX     = 4'd6;  // smooth_x product
   localparam logic [3:0] OP_SMY     = 4'd7;  // smooth_y product
   localparam logic [3:0] OP_SMFIN   = 4'd8;  // smooth write back
   localparam logic [3:0] OP_VEL     = 4'd9;  // gain products
   localparam logic [3:0] OP_RESULT  = 4'd10; // round, clamp, present

   typedef struct packed {
      logic [3:0] op;
      logic       is_ref;
   } cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       cordic_last;
   } stat_type;

   function automatic logic signed [15:0] atan_entry(input logic [StepW-1:0] i);
      logic signed [15:0] v;
      begin
         unique case (i)
            0: v = 16'sd6434;
            1: v = 16'sd3798;
            2: v = 16'sd2007;
            3: v = 16'sd1019;
            4: v = 16'sd511;
            5: v = 16'sd256;
            6: v = 16'sd128;
            7: v = 16'sd64;
            8: v = 16'sd32;
            9: v = 16'sd16;
            10: v = 16'sd8;
            11: v = 16'sd4;
            12: v = 16'sd2;
            13: v = 16'sd1;
            default: v = 16'sd0;
         endcase
         return v;
      end
   endfunction

endpackage

// File: hdl/pvc_ctrl.sv
// ----------------------------------------------------------------------------
// pvc_ctrl
// Sequencer: accepts one item, walks the datapath through its steps.
// ----------------------------------------------------------------------------
module pvc_ctrl
   import pvc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   output logic     item_ready,
   input  logic     rsp_busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_QPREP = 3'd1;
   localparam logic [2:0] S_QROT  = 3'd2;
   localparam logic [2:0] S_CORD  = 3'd3;
   localparam logic [2:0] S_QDONE = 3'd4;
   localparam logic [2:0] S_TICK  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] tick_ff, tick_in;

   assign item_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      tick_in    = tick_ff;
      cmd.op     = OP_NONE;
      cmd.is_ref = (stat.cmd == CMD_REF);
      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               cmd.op = OP_LOAD;
               tick_in = 3'd0;
               state_in = (stat.cmd == CMD_POS) ? S_IDLE : S_QPREP;
            end
         end
         S_QPREP: begin
            // stat.cmd here reflects the captured item
            if (stat.cmd == CMD_TICK) begin
               state_in = S_TICK;
            end else begin
               cmd.op = OP_QPREP;
               state_in = S_QROT;
            end
         end
         S_QROT: begin
            cmd.op = OP_QROT;
            state_in = S_CORD;
         end
         S_CORD: begin
            cmd.op = OP_CSTEP;
            if (stat.cordic_last) state_in = S_QDONE;
         end
         S_QDONE: begin
            cmd.op = OP_QDONE;
            state_in = S_IDLE;
         end
         S_TICK: begin
            unique case (tick_ff)
               3'd0: cmd.op = OP_SMX;
               3'd1: cmd.op = OP_SMY;
               3'd2: cmd.op = OP_SMFIN;
               3'd3: cmd.op = OP_VEL;
               default: cmd.op = rsp_busy ? OP_NONE : OP_RESULT;
            endcase
            if (tick_ff < 3'd4) tick_in = tick_ff + 3'd1;
            else if (!rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tick_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
      end
   end

endmodule

// File: hdl/pvc_datapath.sv
// ----------------------------------------------------------------------------
// pvc_datapath
// State registers, quaternion products, CORDIC, filter and gain stages.
// ----------------------------------------------------------------------------
module pvc_datapath
   import pvc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [1:0]         in_cmd,
   input  logic signed [31:0] in_x,
   input  logic signed [31:0] in_y,
   input  logic signed [31:0] in_z,
   input  logic signed [15:0] in_qx,
   input  logic signed [15:0] in_qy,
   input  logic signed [15:0] in_qz,
   input  logic signed [15:0] in_qw,
   input  logic [15:0]        gain_xy,
   input  logic [15:0]        gain_z,
   input  logic [15:0]        gain_yaw,
   input  logic [30:0]        speed_limit,
   input  logic [30:0]        turn_limit,
   input  logic [16:0]        smoothing,
   output logic [127:0]       result,
   output logic               result_load
);

   logic [1:0] cmd_ff;
   logic signed [15:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [31:0] tx_ff, ty_ff, tz_ff, mx_ff, my_ff, mz_ff, sx_ff, sy_ff;
   logic signed [15:0] th_ff, mh_ff;
   logic signed [35:0] cx_ff, cy_ff;     // CORDIC vector, Q2.28 plus growth
   logic signed [17:0] ang_ff;
   logic               zero_ff;          // heading forced to zero
   logic [StepW-1:0]   step_ff;
   logic signed [50:0] accx_ff, accy_ff;
   logic signed [50:0] pvx_ff, pvy_ff, pvz_ff, pyr_ff;

   // quaternion products
   logic signed [34:0] test_v, num_v, den_v;
   always_comb begin
      test_v = 35'(2 * (35'(qx_ff * qz_ff) - 35'(qw_ff * qy_ff)));
      num_v  = 35'(2 * (35'(qx_ff * qy_ff) + 35'(qw_ff * qz_ff)));
      den_v  = 35'sd268435456 - 35'(2 * (35'(qy_ff * qy_ff) + 35'(qz_ff * qz_ff)));
   end

   // CORDIC step: x moves by the shifted y, y by the shifted x
   logic signed [35:0] dx_v, dy_v;
   assign dx_v = cy_ff >>> step_ff;
   assign dy_v = cx_ff >>> step_ff;

   logic [16:0] s_v;
   assign s_v = (smoothing > 17'd65536) ? 17'd65536 : smoothing;

   function automatic logic signed [31:0] clampv(input logic signed [50:0] p,
                                                 input logic [4:0] k,
                                                 input logic [30:0] lim);
      logic signed [50:0] r, l;
      begin
         r = (p + (51'sd1 <<< (k - 5'd1))) >>> k;
         l = 51'($signed({1'b0, lim}));
         if (r > l) r = l;
         else if (r < -l) r = -l;
         return r[31:0];
      end
   endfunction

   logic signed [16:0] ang_clip;
   always_comb begin
      if (ang_ff > 18'(PiQ13)) ang_clip = 17'(PiQ13);
      else if (ang_ff < -18'(PiQ13)) ang_clip = -17'(PiQ13);
      else ang_clip = ang_ff[16:0];
   end

   assign stat.cmd = cmd_ff;
   assign stat.cordic_last = (step_ff == StepW'(CordicSteps - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff <= '0; ty_ff <= '0; tz_ff <= '0; th_ff <= '0;
         mx_ff <= '0; my_ff <= '0; mz_ff <= '0; mh_ff <= '0;
         sx_ff <= '0; sy_ff <= '0;
         cmd_ff <= CMD_POS;
         result_load <= 1'b0;
      end else begin
         result_load <= 1'b0;
         unique case (cmd.op)
            OP_LOAD: begin
               cmd_ff <= in_cmd;
               qx_ff <= in_qx; qy_ff <= in_qy; qz_ff <= in_qz; qw_ff <= in_qw;
               if (in_cmd == CMD_REF) begin
                  tx_ff <= in_x; ty_ff <= in_y; tz_ff <= in_z;
               end else if (in_cmd == CMD_POS) begin
                  mx_ff <= in_x; my_ff <= in_y; mz_ff <= in_z;
               end
            end
            OP_QPREP: begin
               zero_ff <= (test_v >= 35'sd268435456) || (test_v <= -35'sd268435456)
                          || (num_v == 0 && den_v == 0);
               cx_ff <= 36'(den_v);
               cy_ff <= 36'(num_v);
               ang_ff <= '0;
               step_ff <= '0;
            end
            OP_QROT: begin
               if (cx_ff < 0) begin
                  if (cy_ff >= 0) begin
                     cx_ff <= cy_ff; cy_ff <= -cx_ff; ang_ff <= 18'(HalfPiQ13);
                  end else begin
                     cx_ff <= -cy_ff; cy_ff <= cx_ff; ang_ff <= -18'(HalfPiQ13);
                  end
               end
            end
            OP_CSTEP: begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + dx_v; cy_ff <= cy_ff - dy_v;
                  ang_ff <= ang_ff + 18'(atan_entry(step_ff));
               end else begin
                  cx_ff <= cx_ff - dx_v; cy_ff <= cy_ff + dy_v;
                  ang_ff <= ang_ff - 18'(atan_entry(step_ff));
               end
               step_ff <= step_ff + StepW'(1);
            end
            OP_QDONE: begin
               if (cmd.is_ref) th_ff <= zero_ff ? 16'sd0 : ang_clip[15:0];
               else            mh_ff <= zero_ff ? 16'sd0 : ang_clip[15:0];
            end
            OP_SMX: begin
               accx_ff <= 51'($signed({1'b0, 17'd65536 - s_v}) * sx_ff)
                        + 51'($signed({1'b0, s_v}) * tx_ff);
            end
            OP_SMY: begin
               accy_ff <= 51'($signed({1'b0, 17'd65536 - s_v}) * sy_ff)
                        + 51'($signed({1'b0, s_v}) * ty_ff);
            end
            OP_SMFIN: begin
               sx_ff <= 32'((accx_ff + 51'sd32768) >>> 16);
               sy_ff <= 32'((accy_ff + 51'sd32768) >>> 16);
            end
            OP_VEL: begin
               pvx_ff <= 51'($signed({1'b0, gain_xy}) * (33'(sx_ff) - 33'(mx_ff)));
               pvy_ff <= 51'($signed({1'b0, gain_xy}) * (33'(sy_ff) - 33'(my_ff)));
               pvz_ff <= 51'($signed({1'b0, gain_z}) * (33'(tz_ff) - 33'(mz_ff)));
               pyr_ff <= 51'($signed({1'b0, gain_yaw}) * (17'(th_ff) - 17'(mh_ff)));
            end
            OP_RESULT: begin
               result <= {clampv(pyr_ff, 5'd5, turn_limit),
                          clampv(pvz_ff, 5'd8, speed_limit),
                          clampv(pvy_ff, 5'd8, speed_limit),
                          clampv(pvx_ff, 5'd8, speed_limit)};
               result_load <= 1'b1;
            end
            default: ;
         endcase
      end
   end

endmodule

// File: hdl/position_to_velocity_controller_top.sv
// ----------------------------------------------------------------------------
// position_to_velocity_controller_top
// Proportional position controller with reference smoothing and saturation.
// ----------------------------------------------------------------------------
// channel | direction | contents
// req_    | in        | tuser cmd; tdata coord_x,y,z, quat_x,y,z,w
// rsp_    | out       | tdata vel_x, vel_y, vel_z, turn_rate
// csr_    | in        | write enable, index, 31-bit data
// Steps: a position update is stored in idle; a tick runs the filter, gain and result steps;
// a reference or attitude item runs its CORDIC iterations on one shared add/shift unit.
// rsp_tvalid rises in the cycle after a tick releases req_tready.
// Reset clears all stored positions, headings and the filter; smoothing 0.5.
// A tick waits in its last step while the output register is still full.
// ----------------------------------------------------------------------------
`include "position_to_velocity_controller_top_macros.svh"

module position_to_velocity_controller_top
   import pvc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,  // coord_x, coord_y, coord_z, quat_x, quat_y, quat_z, quat_w
   input  logic [1:0]   req_tuser,  // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // vel_x, vel_y, vel_z, turn_rate
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [30:0]  csr_wdata
);

   cmd_type  cmd;
   stat_type stat;
   logic [15:0] gain_xy_ff, gain_z_ff, gain_yaw_ff;
   logic [30:0] speed_ff, turn_ff;
   logic [16:0] smooth_ff;
   logic [127:0] result;
   logic result_load;
   logic valid_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_xy_ff <= '0; gain_z_ff <= '0; gain_yaw_ff <= '0;
         speed_ff <= '0; turn_ff <= '0; smooth_ff <= 17'd32768;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GAIN_XY:   gain_xy_ff  <= csr_wdata[15:0];
            REG_GAIN_Z:    gain_z_ff   <= csr_wdata[15:0];
            REG_GAIN_YAW:  gain_yaw_ff <= csr_wdata[15:0];
            REG_SPEED_LIM: speed_ff    <= csr_wdata;
            REG_TURN_LIM:  turn_ff     <= csr_wdata;
            REG_SMOOTHING: smooth_ff   <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   pvc_ctrl u_ctrl (
      .clock, .reset,
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .rsp_busy   (valid_ff),
      .stat, .cmd
   );

   stat_type dp_stat;
   // in idle the sequencer looks at the incoming command
   assign stat.cmd = req_tready ? req_tuser : dp_stat.cmd;
   assign stat.cordic_last = dp_stat.cordic_last;

   pvc_datapath u_dp (
      .clock, .reset, .cmd,
      .stat (dp_stat),
      .in_cmd (req_tuser),
      .in_x (req_tdata[31:0]), .in_y (req_tdata[63:32]), .in_z (req_tdata[95:64]),
      .in_qx (req_tdata[111:96]), .in_qy (req_tdata[127:112]),
      .in_qz (req_tdata[143:128]), .in_qw (req_tdata[159:144]),
      .gain_xy (gain_xy_ff), .gain_z (gain_z_ff), .gain_yaw (gain_yaw_ff),
      .speed_limit (speed_ff), .turn_limit (turn_ff), .smoothing (smooth_ff),
      .result, .result_load
   );

   // output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (result_load) valid_ff <= 1'b1;
      else if (rsp_tready) valid_ff <= 1'b0;
   end
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = result;

   // a waiting result holds its data; a new one lands only in an empty register
   `PVC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `PVC_ASSERT_IMPL(a_load_empty, result_load, !valid_ff)
   `PVC_ASSERT_NEXT(a_pos_quick, req_tvalid && req_tready && req_tuser == CMD_POS, req_tready)

endmodule

// File: sim/pvc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pvc_checker
// Watches the item and result channels, predicts each tick's velocity
// commands and compares them with what the controller presents.
// ----------------------------------------------------------------------------
module pvc_checker
   import pvc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [159:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [30:0]  csr_wdata,
   output int           fail_count,
   output int           pending_count,
   output int           command_count
);

   logic [15:0] gain_xy, gain_z, gain_yaw;
   logic [30:0] speed_limit, turn_limit;
   logic [16:0] smoothing;
   logic signed [31:0] target_x, target_y, target_z, meas_x, meas_y, meas_z;
   logic signed [31:0] smooth_x, smooth_y;
   logic signed [15:0] target_heading, meas_heading;
   logic [127:0] expected_cmds[$];

   function automatic longint shift_round(longint v, int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic longint clamp_to(longint v, logic [30:0] lim);
      longint l;
      l = longint'(lim);
      if (v > l) return l;
      if (v < -l) return -l;
      return v;
   endfunction

   function automatic logic signed [15:0] yaw_of(logic [159:0] d);
      longint qx, qy, qz, qw, one, test, y, x, ang, t, dx, dy;
      qx = longint'($signed(d[111:96]));
      qy = longint'($signed(d[127:112]));
      qz = longint'($signed(d[143:128]));
      qw = longint'($signed(d[159:144]));
      one = longint'(1) <<< 28;
      test = 2 * (qx * qz - qw * qy);
      y = 2 * (qx * qy + qw * qz);
      x = one - 2 * (qy * qy + qz * qz);
      ang = 0;
      if (test >= one || test <= -one) return 16'sd0;
      if (x == 0 && y == 0) return 16'sd0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; ang = HalfPiQ13;
         end else begin
            x = -y; y = t; ang = -HalfPiQ13;
         end
      end
      for (int i = 0; i < CordicSteps && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; ang += longint'(atan_entry(StepW'(i)));
         end else begin
            x -= dx; y += dy; ang -= longint'(atan_entry(StepW'(i)));
         end
      end
      if (ang > PiQ13) ang = PiQ13;
      if (ang < -PiQ13) ang = -PiQ13;
      return ang[15:0];
   endfunction

   function automatic logic signed [31:0] filter_step(logic signed [31:0] prev,
         logic signed [31:0] tgt, longint s);
      longint acc;
      acc = (65536 - s) * longint'(prev) + s * longint'(tgt);
      return 32'(shift_round(acc, 16));
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      longint s, vx, vy, vz, yr;
      logic [127:0] want;
      if (reset) begin
         gain_xy = 0; gain_z = 0; gain_yaw = 0;
         speed_limit = 0; turn_limit = 0; smoothing = 17'd32768;
         target_x = 0; target_y = 0; target_z = 0; target_heading = 0;
         meas_x = 0; meas_y = 0; meas_z = 0; meas_heading = 0;
         smooth_x = 0; smooth_y = 0;
         expected_cmds.delete();
         fail_count = 0;
         command_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_GAIN_XY:   gain_xy = csr_wdata[15:0];
               REG_GAIN_Z:    gain_z = csr_wdata[15:0];
               REG_GAIN_YAW:  gain_yaw = csr_wdata[15:0];
               REG_SPEED_LIM: speed_limit = csr_wdata;
               REG_TURN_LIM:  turn_limit = csr_wdata;
               REG_SMOOTHING: smoothing = csr_wdata[16:0];
               default: ;
            endcase
         end
         // compare the result first; a new tick cannot be answered in the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cmds.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[31:0], 32'd0);
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_tdata[31:0] !== want[31:0])
                  report_mismatch("vel_x", rsp_tdata[31:0], want[31:0]);
               if (rsp_tdata[63:32] !== want[63:32])
                  report_mismatch("vel_y", rsp_tdata[63:32], want[63:32]);
               if (rsp_tdata[95:64] !== want[95:64])
                  report_mismatch("vel_z", rsp_tdata[95:64], want[95:64]);
               if (rsp_tdata[127:96] !== want[127:96])
                  report_mismatch("turn_rate", rsp_tdata[127:96], want[127:96]);
               command_count++;
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               CMD_REF: begin
                  target_x = req_tdata[31:0];
                  target_y = req_tdata[63:32];
                  target_z = req_tdata[95:64];
                  target_heading = yaw_of(req_tdata);
               end
               CMD_POS: begin
                  meas_x = req_tdata[31:0];
                  meas_y = req_tdata[63:32];
                  meas_z = req_tdata[95:64];
               end
               CMD_ATT: meas_heading = yaw_of(req_tdata);
               default: begin
                  s = smoothing > 17'd65536 ? 65536 : longint'(smoothing);
                  smooth_x = filter_step(smooth_x, target_x, s);
                  smooth_y = filter_step(smooth_y, target_y, s);
                  vx = shift_round(longint'(gain_xy) *
                        (longint'(smooth_x) - longint'(meas_x)), 8);
                  vy = shift_round(longint'(gain_xy) *
                        (longint'(smooth_y) - longint'(meas_y)), 8);
                  vz = shift_round(longint'(gain_z) *
                        (longint'(target_z) - longint'(meas_z)), 8);
                  yr = shift_round(longint'(gain_yaw) *
                        (longint'(target_heading) - longint'(meas_heading)), 5);
                  vx = clamp_to(vx, speed_limit);
                  vy = clamp_to(vy, speed_limit);
                  vz = clamp_to(vz, speed_limit);
                  yr = clamp_to(yr, turn_limit);
                  expected_cmds.insert(expected_cmds.size(),
                                       {yr[31:0], vz[31:0], vy[31:0], vx[31:0]});
               end
            endcase
         end
      end
      pending_count = expected_cmds.size();
   end

endmodule

// File: sim/tb_position_to_velocity_controller_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_position_to_velocity_controller_top
// Drives reference, position, attitude and tick items with random gaps and
// back-pressure through several register settings; a checker predicts and
// compares every velocity command.
// ----------------------------------------------------------------------------
module tb_position_to_velocity_controller_top
   import pvc_pkg::*;
   ();

   localparam int WatchdogLimit = 20000;
   localparam logic [2:0] RegUnlisted = 3'd7;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;   // coord_x, coord_y, coord_z, quat_x, quat_y, quat_z, quat_w
   logic [1:0]   req_tuser = '0;   // cmd
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;        // vel_x, vel_y, vel_z, turn_rate
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [30:0]  csr_wdata = '0;

   int fail_count, pending_count, command_count;
   int item_count = 0;
   int idle_cycles = 0;

   always #2 clock = ~clock;

   position_to_velocity_controller_top uut (.*);

   pvc_checker checker_i (.*);

   // watchdog: count edges on which neither channel moves an item and no register is written
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchdogLimit) begin
         $display("watchdog expired");
         $display("tb: failure");
         $finish;
      end
   end

   // pick a gap: mostly none or short, now and then a long one
   function automatic int gap_len(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // result side: random stalls, with calm stretches of full readiness
   bit sink_calm = 1'b0;
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) sink_calm <= ~sink_calm;
      if (reset)
         rsp_tready <= 1'b0;
      else if (sink_calm)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(0, 99) < 60) ||
                       ($urandom_range(0, 29) == 0 ? 1'b0 : 1'b0);
   end

   // raise the write for one edge; the caller drops csr_we after the last one
   task automatic write_reg(logic [2:0] idx, logic [30:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // hold the item until the controller takes it, after an optional gap
   task automatic send_item(logic [1:0] cmd, logic [159:0] data, bit quiet);
      int gap;
      gap = gap_len(quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item_count++;
   endtask

   function automatic logic [159:0] pack(logic [31:0] cx, logic [31:0] cy,
         logic [31:0] cz, logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
         logic [15:0] qw);
      return {qw, qz, qy, qx, cz, cy, cx};
   endfunction

   function automatic logic [15:0] rand_q();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'sd16384;
      if (r == 1) return -16'sd16384;
      if (r == 2) return 16'($urandom());   // out of range components too
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic logic [31:0] rand_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h8000_0000;
      if (r == 1) return 32'h7FFF_FFFF;
      if (r < 5) return $urandom();
      return 32'($signed($urandom_range(0, 2000000)) - 1000000);
   endfunction

   // mostly a roughly unit quaternion from a random yaw so that the normal path runs, else random components
   function automatic logic [159:0] rand_pose();
      real a;
      logic [15:0] qz, qw;
      a = ($urandom_range(0, 62831) / 10000.0) - 3.14159;
      qz = 16'($rtoi($sin(a / 2.0) * 16384.0));
      qw = 16'($rtoi($cos(a / 2.0) * 16384.0));
      if ($urandom_range(0, 3) == 0)
         return pack(rand_coord(), rand_coord(), rand_coord(), rand_q(), rand_q(),
                     rand_q(), rand_q());
      return pack(rand_coord(), rand_coord(), rand_coord(),
                  16'($signed($urandom_range(0, 400)) - 200),
                  16'($signed($urandom_range(0, 400)) - 200), qz, qw);
   endfunction

   // drop the item line and let the block drain before touching registers
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_settings(int phase);
      case (phase)
         0: begin
            write_reg(REG_GAIN_XY, 31'd65535); write_reg(REG_GAIN_Z, 31'd65535);
            write_reg(REG_GAIN_YAW, 31'd65535);
            write_reg(REG_SPEED_LIM, 31'h7FFF_FFFF);
            write_reg(REG_TURN_LIM, 31'h7FFF_FFFF);
            write_reg(REG_SMOOTHING, 31'd65536);
         end
         1: begin
            write_reg(REG_GAIN_XY, 31'd0); write_reg(REG_GAIN_Z, 31'd0);
            write_reg(REG_GAIN_YAW, 31'd0); write_reg(REG_SPEED_LIM, 31'd0);
            write_reg(REG_TURN_LIM, 31'd0); write_reg(REG_SMOOTHING, 31'd0);
         end
         2: write_reg(REG_SMOOTHING, 31'h1FFFF);  // above one
         default: begin
            write_reg(REG_GAIN_XY, 31'($urandom_range(0, 65535)));
            write_reg(REG_GAIN_Z, 31'($urandom_range(0, 65535)));
            write_reg(REG_GAIN_YAW, 31'($urandom_range(0, 65535)));
            write_reg(REG_SPEED_LIM, 31'($urandom() >> 1 >> $urandom_range(0, 20)));
            write_reg(REG_TURN_LIM, 31'($urandom() >> 1 >> $urandom_range(0, 20)));
            write_reg(REG_SMOOTHING, 31'($urandom_range(0, 70000)));
         end
      endcase
      write_reg(RegUnlisted, 31'($urandom()));   // unlisted index: must be ignored
      csr_we <= 1'b0;
   endtask

   initial begin
      int r;
      logic [1:0] c;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero quaternion, near gimbal lock, every command
      random_settings(0);
      send_item(CMD_TICK, '0, 1'b1);
      send_item(CMD_REF, pack(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                16'd0, 16'd0, 16'd0, 16'd0), 1'b1);
      send_item(CMD_POS, pack(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                16'd0, 16'd0, 16'd0, 16'd0), 1'b1);
      send_item(CMD_ATT, pack(0, 0, 0, 16'sd11585, 16'sd0, 16'sd11585, 16'sd0), 1'b1);
      send_item(CMD_TICK, '0, 1'b1);
      send_item(CMD_ATT, pack(0, 0, 0, 16'sd0, -16'sd11585, 16'sd0, 16'sd11585), 1'b1);
      send_item(CMD_REF, pack(0, 0, 0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0), 1'b1);
      send_item(CMD_TICK, '0, 1'b1);
      send_item(CMD_REF, pack(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
      send_item(CMD_ATT, pack(0, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000), 1'b1);
      send_item(CMD_TICK, '0, 1'b1);
      send_item(CMD_ATT, pack(0, 0, 0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0), 1'b1);
      send_item(CMD_TICK, {160{1'b1}}, 1'b1);

      // random phases with register changes between them
      for (int phase = 1; phase < 12; phase++) begin
         wait_drained();
         random_settings(phase == 11 ? 0 : phase);
         for (int n = 0; n < 170; n++) begin
            r = $urandom_range(0, 99);
            c = r < 20 ? CMD_REF : r < 45 ? CMD_POS : r < 60 ? CMD_ATT : CMD_TICK;
            send_item(c, rand_pose(), phase[0]);
         end
      end
      wait_drained();

      $display("%0d items sent, %0d velocity commands checked over 12 settings",
               item_count, command_count);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/pvc_pkg.sv
hdl/pvc_ctrl.sv
hdl/pvc_datapath.sv
hdl/position_to_velocity_controller_top.sv
sim/pvc_checker.sv
sim/tb_position_to_velocity_controller_top.sv
